// ===== rtl/pidc_pkg.sv =====
// ----------------------------------------------------------------------------
// PID controller package
// Shared codes, register indexes and the command and status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int ERROR_W     = 32;
   localparam int DRIVE_W     = 32;
   localparam int DAMPING_W   = 31;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I_DIVISOR = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_LIMIT    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWER_LIMIT    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAMPING        = 3'd5;

   localparam logic [2:0] MA_ACC   = 3'd0;
   localparam logic [2:0] MA_UPPER = 3'd1;
   localparam logic [2:0] MA_LOWER = 3'd2;
   localparam logic [2:0] MA_DIFF  = 3'd3;
   localparam logic [2:0] MA_SUM   = 3'd4;

   localparam logic [1:0] MB_GP = 2'd0;
   localparam logic [1:0] MB_GI = 2'd1;
   localparam logic [1:0] MB_GD = 2'd2;

   localparam logic [1:0] DA_E    = 2'd0;
   localparam logic [1:0] DA_PROD = 2'd1;
   localparam logic [1:0] DA_ACC  = 2'd2;

   localparam logic [1:0] DB_DD = 2'd0;
   localparam logic [1:0] DB_GI = 2'd1;
   localparam logic [1:0] DB_GP = 2'd2;

   typedef struct packed {
      logic       load_e;
      logic       clear;
      logic       mul_start;
      logic [2:0] mul_a_sel;
      logic [1:0] mul_b_sel;
      logic       div_start;
      logic [1:0] div_a_sel;
      logic [1:0] div_b_sel;
      logic       e_from_div;
      logic       acc_from_sum;
      logic       acc_from_div;
      logic       commit_integ;
      logic       ci_from_div;
      logic       ci_zero;
      logic       sum_from_mul;
      logic       prev_from_e;
      logic       res_from_mul;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic dd_zero;
      logic clamp_en;
      logic gi_zero;
      logic mul_done;
      logic div_done;
      logic over;
      logic under;
   } status_type;

endpackage

// ===== rtl/pid_controller_int32.sv =====
// ----------------------------------------------------------------------------
// PID controller, 32-bit integer
// Discrete PID controller with a damped error, trapezoid integral,
// integral clamping against scaled limits and a derivative term.
//
//   Channel | Handshake             | Word
//   --------+-----------------------+-----------------------------------
//   req     | req_valid / req_stall | req_cmd, req_error_in
//   rsp     | rsp_valid / rsp_stall | rsp_drive
//   csr     | csr_valid / csr_ready | csr_index, csr_wdata
//
// One word is worked at a time. A clear goes from idle straight to the
// result state. An update runs from 0 to 6 divisions on the
// one-bit-per-cycle divider and from 2 to 6 multiplications.
// Reset is synchronous and restores the register defaults and zero state.
// A waiting result does not block the next request; csr_ready stays high.
// ----------------------------------------------------------------------------
module pid_controller_int32 #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_cmd,
   input  logic [pidc_pkg::ERROR_W-1:0]     req_error_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [pidc_pkg::DRIVE_W-1:0]     rsp_drive,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pidc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pidc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   pidc_pkg::cmd_type    cmd;
   pidc_pkg::status_type status;

   assign csr_ready = 1'b1;

   pidc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pidc_dp #(.W(DATA_WIDTH)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_error_in (req_error_in),
      .cmd          (cmd),
      .status       (status),
      .rsp_drive    (rsp_drive)
   );

endmodule

// ===== rtl/pidc_mul.sv =====
// ----------------------------------------------------------------------------
// PID controller multiplier
// Digit-serial multiplier that forms the low word of a product, eight bits
// of the second operand per cycle.
// ----------------------------------------------------------------------------
module pidc_mul #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic         done,
   output logic [W-1:0] product
);

   localparam int DIG  = 8;
   localparam int MCYC = (W + DIG - 1) / DIG;
   localparam int CW   = $clog2(MCYC + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  p_ff, p_in;
   logic [W+DIG-1:0] pp;

   always_comb begin
      pp      = (W+DIG)'(a_ff) * (W+DIG)'(b_ff[DIG-1:0]);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      p_in    = p_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = a;
         b_in    = b;
         p_in    = '0;
      end else if (busy_ff) begin
         p_in   = p_ff + pp[W-1:0];
         a_in   = {a_ff[W-DIG-1:0], DIG'(0)};
         b_in   = {DIG'(0), b_ff[W-1:DIG]};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(MCYC - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      p_ff   <= p_in;
   end

   assign done    = done_ff;
   assign product = p_ff;

endmodule

// ===== rtl/pidc_div.sv =====
// ----------------------------------------------------------------------------
// PID controller divider
// Restoring divider on magnitudes, one quotient bit per cycle, with the
// sign of the quotient applied at its output.
// ----------------------------------------------------------------------------
module pidc_div #(
   parameter int W   = 32,
   parameter int DVW = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   dividend,
   input  logic [DVW-1:0] divisor,
   input  logic           negate,
   output logic           done,
   output logic [W-1:0]   quotient
);

   localparam int CW = $clog2(W + 1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [DVW-1:0] rem_ff, rem_in;
   logic [W-1:0]   quo_ff, quo_in;
   logic [DVW-1:0] dvs_ff, dvs_in;
   logic           neg_ff, neg_in;
   logic [DVW:0]   trial;
   logic [DVW:0]   diff;
   logic           ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[W-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         neg_in  = negate;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVW-1:0] : trial[DVW-1:0];
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (W'(0) - quo_ff) : quo_ff;

endmodule

// ===== rtl/pidc_dp.sv =====
// ----------------------------------------------------------------------------
// PID controller datapath
// Configuration registers, controller state, working registers and the
// shared multiplier and divider, steered by the controller's commands.
// ----------------------------------------------------------------------------
module pidc_dp #(
   parameter int W = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pidc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pidc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [pidc_pkg::ERROR_W-1:0]        req_error_in,
   input  pidc_pkg::cmd_type                   cmd,
   output pidc_pkg::status_type                status,
   output logic [pidc_pkg::DRIVE_W-1:0]        rsp_drive
);

   localparam int UW = (W > pidc_pkg::DAMPING_W) ? W : pidc_pkg::DAMPING_W;

   function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
      return v[W-1] ? (W'(0) - v) : v;
   endfunction

   logic [W-1:0] gp_ff, gp_in;
   logic [W-1:0] gi_ff, gi_in;
   logic [W-1:0] gd_ff, gd_in;
   logic [W-1:0] up_ff, up_in;
   logic [W-1:0] lo_ff, lo_in;
   logic [pidc_pkg::DAMPING_W-1:0] dd_ff, dd_in;
   logic [W-1:0] integ_ff, integ_in;
   logic [W-1:0] prev_ff, prev_in;
   logic [W-1:0] e_ff, e_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] ci_ff, ci_in;
   logic [W-1:0] sum_ff, sum_in;
   logic [W-1:0] res_ff, res_in;
   logic [pidc_pkg::DRIVE_W-1:0] drive_ff, drive_in;

   logic [W-1:0]  csr_val;
   logic [W-1:0]  half;
   logic [W-1:0]  diff;
   logic [W-1:0]  mul_a, mul_b, prod;
   logic          mul_done;
   logic [W-1:0]  div_a_raw, quot;
   logic [UW-1:0] div_b;
   logic          div_b_neg;
   logic          div_done;

   assign csr_val = W'($signed(csr_wdata));
   assign half    = {sum_ff[W-1], sum_ff[W-1:1]};
   assign diff    = e_ff - prev_ff;

   always_comb begin
      unique case (cmd.mul_a_sel)
         pidc_pkg::MA_ACC:   mul_a = acc_ff;
         pidc_pkg::MA_UPPER: mul_a = up_ff;
         pidc_pkg::MA_LOWER: mul_a = lo_ff;
         pidc_pkg::MA_DIFF:  mul_a = diff;
         default:            mul_a = sum_ff;
      endcase
      unique case (cmd.mul_b_sel)
         pidc_pkg::MB_GP: mul_b = gp_ff;
         pidc_pkg::MB_GI: mul_b = gi_ff;
         default:         mul_b = gd_ff;
      endcase
      unique case (cmd.div_a_sel)
         pidc_pkg::DA_E:    div_a_raw = e_ff;
         pidc_pkg::DA_PROD: div_a_raw = prod;
         default:           div_a_raw = acc_ff;
      endcase
      unique case (cmd.div_b_sel)
         pidc_pkg::DB_DD: begin
            div_b     = UW'(dd_ff);
            div_b_neg = 1'b0;
         end
         pidc_pkg::DB_GI: begin
            div_b     = UW'(mag_of(gi_ff));
            div_b_neg = gi_ff[W-1];
         end
         default: begin
            div_b     = UW'(mag_of(gp_ff));
            div_b_neg = gp_ff[W-1];
         end
      endcase
   end

   pidc_mul #(.W(W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (prod)
   );

   pidc_div #(.W(W), .DVW(UW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (mag_of(div_a_raw)),
      .divisor  (div_b),
      .negate   (div_a_raw[W-1] ^ div_b_neg),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      gp_in    = gp_ff;
      gi_in    = gi_ff;
      gd_in    = gd_ff;
      up_in    = up_ff;
      lo_in    = lo_ff;
      dd_in    = dd_ff;
      integ_in = integ_ff;
      prev_in  = prev_ff;
      e_in     = e_ff;
      acc_in   = acc_ff;
      ci_in    = ci_ff;
      sum_in   = sum_ff;
      res_in   = res_ff;
      drive_in = drive_ff;
      if (csr_we) begin
         case (csr_index)
            pidc_pkg::CSR_GAIN_P:         gp_in = csr_val;
            pidc_pkg::CSR_GAIN_I_DIVISOR: gi_in = csr_val;
            pidc_pkg::CSR_GAIN_D:         gd_in = csr_val;
            pidc_pkg::CSR_UPPER_LIMIT:    up_in = csr_val;
            pidc_pkg::CSR_LOWER_LIMIT:    lo_in = csr_val;
            pidc_pkg::CSR_DAMPING:        dd_in = csr_wdata[pidc_pkg::DAMPING_W-1:0];
            default: ;
         endcase
      end
      if (cmd.load_e) begin
         e_in   = W'($signed(req_error_in));
         sum_in = W'($signed(req_error_in)) + prev_ff;
      end
      if (cmd.clear) begin
         integ_in = '0;
         prev_in  = '0;
         res_in   = '0;
      end
      if (cmd.e_from_div) begin
         e_in   = quot;
         sum_in = quot + prev_ff;
      end
      if (cmd.acc_from_sum) begin
         acc_in = integ_ff + half;
      end
      if (cmd.acc_from_div) begin
         acc_in = quot;
      end
      if (cmd.commit_integ) begin
         integ_in = acc_ff;
      end
      if (cmd.ci_zero) begin
         ci_in = '0;
      end
      if (cmd.ci_from_div) begin
         ci_in = quot;
      end
      if (cmd.sum_from_mul) begin
         sum_in = e_ff + ci_ff + prod;
      end
      if (cmd.prev_from_e) begin
         prev_in = e_ff;
      end
      if (cmd.res_from_mul) begin
         res_in = prod;
      end
      if (cmd.out_load) begin
         drive_in = pidc_pkg::DRIVE_W'(res_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gp_ff    <= W'(1);
         gi_ff    <= '0;
         gd_ff    <= '0;
         up_ff    <= W'($signed(32'h7FFF_FFFF));
         lo_ff    <= W'($signed(32'h8000_0000));
         dd_ff    <= pidc_pkg::DAMPING_W'(1);
         integ_ff <= '0;
         prev_ff  <= '0;
      end else begin
         gp_ff    <= gp_in;
         gi_ff    <= gi_in;
         gd_ff    <= gd_in;
         up_ff    <= up_in;
         lo_ff    <= lo_in;
         dd_ff    <= dd_in;
         integ_ff <= integ_in;
         prev_ff  <= prev_in;
      end
      e_ff     <= e_in;
      acc_ff   <= acc_in;
      ci_ff    <= ci_in;
      sum_ff   <= sum_in;
      res_ff   <= res_in;
      drive_ff <= drive_in;
   end

   assign status.dd_zero  = (dd_ff == '0);
   assign status.clamp_en = (gp_ff != '0) && (gi_ff != '0);
   assign status.gi_zero  = (gi_ff == '0);
   assign status.mul_done = mul_done;
   assign status.div_done = div_done;
   assign status.over     = $signed(quot) > $signed(up_ff);
   assign status.under    = $signed(lo_ff) > $signed(quot);
   assign rsp_drive       = drive_ff;

endmodule

// ===== rtl/pidc_ctrl.sv =====
// ----------------------------------------------------------------------------
// PID controller sequencer
// State machine that walks each update through damping and clamping where
// enabled, integration, the derivative term and output, issuing operations to the shared units.
// ----------------------------------------------------------------------------
module pidc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_cmd,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  pidc_pkg::status_type status,
   output pidc_pkg::cmd_type    cmd
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DAMP   = 5'd1;
   localparam logic [4:0] S_DAMP_W = 5'd2;
   localparam logic [4:0] S_ACC    = 5'd3;
   localparam logic [4:0] S_T1     = 5'd4;
   localparam logic [4:0] S_T1_M   = 5'd5;
   localparam logic [4:0] S_T1_D   = 5'd6;
   localparam logic [4:0] S_C1_M   = 5'd7;
   localparam logic [4:0] S_C1_D   = 5'd8;
   localparam logic [4:0] S_T2     = 5'd9;
   localparam logic [4:0] S_T2_M   = 5'd10;
   localparam logic [4:0] S_T2_D   = 5'd11;
   localparam logic [4:0] S_C2_M   = 5'd12;
   localparam logic [4:0] S_C2_D   = 5'd13;
   localparam logic [4:0] S_CI     = 5'd14;
   localparam logic [4:0] S_CI_W   = 5'd15;
   localparam logic [4:0] S_CD_W   = 5'd16;
   localparam logic [4:0] S_DR     = 5'd17;
   localparam logic [4:0] S_DR_W   = 5'd18;
   localparam logic [4:0] S_DONE   = 5'd19;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_cmd == pidc_pkg::CMD_CLEAR) begin
                  cmd.clear = 1'b1;
                  state_in  = S_DONE;
               end else begin
                  cmd.load_e = 1'b1;
                  state_in   = S_DAMP;
               end
            end
         end
         S_DAMP: begin
            if (status.dd_zero) begin
               state_in = S_ACC;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_a_sel = pidc_pkg::DA_E;
               cmd.div_b_sel = pidc_pkg::DB_DD;
               state_in      = S_DAMP_W;
            end
         end
         S_DAMP_W: begin
            if (status.div_done) begin
               cmd.e_from_div = 1'b1;
               state_in       = S_ACC;
            end
         end
         S_ACC: begin
            cmd.acc_from_sum = 1'b1;
            state_in         = status.clamp_en ? S_T1 : S_CI;
         end
         S_T1, S_T2: begin
            cmd.mul_start = 1'b1;
            cmd.mul_a_sel = pidc_pkg::MA_ACC;
            cmd.mul_b_sel = pidc_pkg::MB_GP;
            state_in      = (state_ff == S_T1) ? S_T1_M : S_T2_M;
         end
         S_T1_M, S_T2_M: begin
            if (status.mul_done) begin
               cmd.div_start = 1'b1;
               cmd.div_a_sel = pidc_pkg::DA_PROD;
               cmd.div_b_sel = pidc_pkg::DB_GI;
               state_in      = (state_ff == S_T1_M) ? S_T1_D : S_T2_D;
            end
         end
         S_T1_D: begin
            if (status.div_done) begin
               if (status.over) begin
                  cmd.mul_start = 1'b1;
                  cmd.mul_a_sel = pidc_pkg::MA_UPPER;
                  cmd.mul_b_sel = pidc_pkg::MB_GI;
                  state_in      = S_C1_M;
               end else begin
                  state_in = S_T2;
               end
            end
         end
         S_T2_D: begin
            if (status.div_done) begin
               if (status.under) begin
                  cmd.mul_start = 1'b1;
                  cmd.mul_a_sel = pidc_pkg::MA_LOWER;
                  cmd.mul_b_sel = pidc_pkg::MB_GI;
                  state_in      = S_C2_M;
               end else begin
                  state_in = S_CI;
               end
            end
         end
         S_C1_M, S_C2_M: begin
            if (status.mul_done) begin
               cmd.div_start = 1'b1;
               cmd.div_a_sel = pidc_pkg::DA_PROD;
               cmd.div_b_sel = pidc_pkg::DB_GP;
               state_in      = (state_ff == S_C1_M) ? S_C1_D : S_C2_D;
            end
         end
         S_C1_D, S_C2_D: begin
            if (status.div_done) begin
               cmd.acc_from_div = 1'b1;
               state_in         = (state_ff == S_C1_D) ? S_T2 : S_CI;
            end
         end
         S_CI: begin
            cmd.commit_integ = 1'b1;
            if (status.gi_zero) begin
               cmd.ci_zero   = 1'b1;
               cmd.mul_start = 1'b1;
               cmd.mul_a_sel = pidc_pkg::MA_DIFF;
               cmd.mul_b_sel = pidc_pkg::MB_GD;
               state_in      = S_CD_W;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_a_sel = pidc_pkg::DA_ACC;
               cmd.div_b_sel = pidc_pkg::DB_GI;
               state_in      = S_CI_W;
            end
         end
         S_CI_W: begin
            if (status.div_done) begin
               cmd.ci_from_div = 1'b1;
               cmd.mul_start   = 1'b1;
               cmd.mul_a_sel   = pidc_pkg::MA_DIFF;
               cmd.mul_b_sel   = pidc_pkg::MB_GD;
               state_in        = S_CD_W;
            end
         end
         S_CD_W: begin
            if (status.mul_done) begin
               cmd.sum_from_mul = 1'b1;
               cmd.prev_from_e  = 1'b1;
               state_in         = S_DR;
            end
         end
         S_DR: begin
            cmd.mul_start = 1'b1;
            cmd.mul_a_sel = pidc_pkg::MA_SUM;
            cmd.mul_b_sel = pidc_pkg::MB_GP;
            state_in      = S_DR_W;
         end
         S_DR_W: begin
            if (status.mul_done) begin
               cmd.res_from_mul = 1'b1;
               state_in         = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_cmd == pidc_pkg::CMD_CLEAR)
      |=> (state_ff == S_DONE))
      else $error("Clear word did not go straight to the result state.");

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.mul_start && cmd.div_start))
      else $error("Multiplier and divider were started together.");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("Result word appeared outside the result state.");

   a_mul_wait: assert property (@(posedge clock) disable iff (reset)
      status.mul_done |-> (state_ff == S_T1_M || state_ff == S_T2_M ||
                           state_ff == S_C1_M || state_ff == S_C2_M ||
                           state_ff == S_CD_W || state_ff == S_DR_W))
      else $error("Multiplier finished while no state waited for it.");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_DAMP_W || state_ff == S_T1_D ||
                           state_ff == S_T2_D || state_ff == S_C1_D ||
                           state_ff == S_C2_D || state_ff == S_CI_W))
      else $error("Divider finished while no state waited for it.");

endmodule
